// File: sv/bpcs_pkg.sv
package bpcs_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned THR_W  = 16;
    localparam int unsigned BLK_W  = 4;
    localparam int unsigned STEP_W = 5;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned DIV_CNT_W  = 6;

    localparam logic [THR_W-1:0] THR_RESET       = 16'd500;
    localparam logic [BLK_W-1:0] SHORT_BLK_RESET = 4'd5;
    localparam logic [BLK_W-1:0] LONG_BLK_RESET  = 4'd10;

    localparam logic [1:0] OP_SAMPLE  = 2'd0;
    localparam logic [1:0] OP_MONITOR = 2'd1;
    localparam logic [1:0] OP_REPORT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_BLINK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_BLINK  = 2'd2;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DATA_W-1:0] quotient;
    } t_div_sts;

endpackage

// File: sv/bpcs_div.sv
module bpcs_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bpcs_pkg::t_div_req i_req,
    output bpcs_pkg::t_div_sts o_sts
);

    logic                               r_busy, n_busy;
    logic                               r_done, n_done;
    logic [bpcs_pkg::DIV_CNT_W-1:0]     r_cnt, n_cnt;
    logic [bpcs_pkg::DATA_W-1:0]        r_rem, n_rem;
    logic [bpcs_pkg::DATA_W-1:0]        r_quo, n_quo;
    logic [bpcs_pkg::DATA_W-1:0]        r_dvs, n_dvs;
    logic [bpcs_pkg::DATA_W:0]          shifted;
    logic [bpcs_pkg::DATA_W:0]          diff;

    // one restoring step: shift in the next dividend bit, try the subtract
    assign shifted = {r_rem, r_quo[bpcs_pkg::DATA_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = bpcs_pkg::DIV_CNT_W'(bpcs_pkg::DATA_W);
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            if (diff[bpcs_pkg::DATA_W]) begin
                n_rem = shifted[bpcs_pkg::DATA_W-1:0];
                n_quo = {r_quo[bpcs_pkg::DATA_W-2:0], 1'b0};
            end else begin
                n_rem = diff[bpcs_pkg::DATA_W-1:0];
                n_quo = {r_quo[bpcs_pkg::DATA_W-2:0], 1'b1};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == bpcs_pkg::DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_sts.busy     = r_busy;
    assign o_sts.done     = r_done;
    assign o_sts.quotient = r_quo;

endmodule

// File: sv/button_press_classifier_stats_top.sv
// Button press classifier with press statistics.
// Input channel (i_in_valid / o_in_ready) carries one beat per item: i_op
// selects a button sample (i_button_level, i_now_ms), a monitor tick that
// counts a finished press and steps the yellow blink, or a report tick.
// Every accepted beat yields exactly one output beat (o_out_valid /
// i_out_ready) with the LED states after the item; a report tick also
// carries the counts and mean press duration, after which counts and sums
// are cleared.
// Samples, monitor ticks, unused op codes and reports with no presses go
// from acceptance to the done state and then into the output register; a
// report with presses first waits for the bit-serial divider (32 steps).
// The block takes no new item while one is in flight: o_in_ready is high
// only while the sequencer is idle, and the output register lets the next
// item be taken while a finished result waits.
// If the receiver stalls, the result holds in the output register and the
// sequencer waits until a slot frees before finishing the next item.
// Reset (synchronous, active low) clears control state, not the output
// register, and restores threshold (500 ms) and blinks (5 short, 10 long).
// Configuration writes (i_cfg_wr_en, i_cfg_idx, i_cfg_data) take effect at
// once and must be made while the block is idle.
module button_press_classifier_stats_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [bpcs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bpcs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_op,
    input  logic                               i_button_level,
    input  logic [bpcs_pkg::DATA_W-1:0]        i_now_ms,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_green_led,
    output logic                               o_red_led,
    output logic                               o_yellow_led,
    output logic                               o_report_valid,
    output logic [bpcs_pkg::DATA_W-1:0]        o_total_count,
    output logic [bpcs_pkg::DATA_W-1:0]        o_short_count,
    output logic [bpcs_pkg::DATA_W-1:0]        o_long_count,
    output logic [bpcs_pkg::DATA_W-1:0]        o_average_ms,
    output logic                               o_average_valid
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    localparam int unsigned W = bpcs_pkg::DATA_W;

    t_state                          r_state, n_state;

    logic [bpcs_pkg::THR_W-1:0]      r_thr;
    logic [bpcs_pkg::BLK_W-1:0]      r_sblk;
    logic [bpcs_pkg::BLK_W-1:0]      r_lblk;

    logic                            r_pressed, n_pressed;
    logic [W-1:0]                    r_start, n_start;
    logic                            r_pending, n_pending;
    logic [W-1:0]                    r_dur, n_dur;
    logic                            r_long, n_long;
    logic [W-1:0]                    r_cnt_tot, n_cnt_tot;
    logic [W-1:0]                    r_cnt_s, n_cnt_s;
    logic [W-1:0]                    r_cnt_l, n_cnt_l;
    logic [W-1:0]                    r_sum_s, n_sum_s;
    logic [W-1:0]                    r_sum_l, n_sum_l;
    logic [bpcs_pkg::STEP_W-1:0]     r_step, n_step;
    logic [bpcs_pkg::STEP_W-1:0]     r_goal, n_goal;
    logic                            r_grn, n_grn;
    logic                            r_red, n_red;
    logic                            r_yel, n_yel;

    logic                            r_rep, n_rep;
    logic [W-1:0]                    r_rep_tot, n_rep_tot;
    logic [W-1:0]                    r_rep_s, n_rep_s;
    logic [W-1:0]                    r_rep_l, n_rep_l;

    logic                            r_out_valid, n_out_valid;
    logic                            r_o_grn, r_o_red, r_o_yel, r_o_rep, r_o_avg_v;
    logic [W-1:0]                    r_o_tot, r_o_s, r_o_l, r_o_avg;

    logic                            accept;
    logic                            out_free;
    logic [W-1:0]                    dur;
    logic [bpcs_pkg::STEP_W-1:0]     goal_m, step_m;
    bpcs_pkg::t_div_req              div_req;
    bpcs_pkg::t_div_sts              div_sts;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign dur        = i_now_ms - r_start;

    bpcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_sts   (div_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= bpcs_pkg::THR_RESET;
            r_sblk <= bpcs_pkg::SHORT_BLK_RESET;
            r_lblk <= bpcs_pkg::LONG_BLK_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                bpcs_pkg::CFG_THRESHOLD:   r_thr  <= i_cfg_data;
                bpcs_pkg::CFG_SHORT_BLINK: r_sblk <= i_cfg_data[bpcs_pkg::BLK_W-1:0];
                bpcs_pkg::CFG_LONG_BLINK:  r_lblk <= i_cfg_data[bpcs_pkg::BLK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state   = r_state;
        n_pressed = r_pressed;
        n_start   = r_start;
        n_pending = r_pending;
        n_dur     = r_dur;
        n_long    = r_long;
        n_cnt_tot = r_cnt_tot;
        n_cnt_s   = r_cnt_s;
        n_cnt_l   = r_cnt_l;
        n_sum_s   = r_sum_s;
        n_sum_l   = r_sum_l;
        n_step    = r_step;
        n_goal    = r_goal;
        n_grn     = r_grn;
        n_red     = r_red;
        n_yel     = r_yel;
        n_rep     = r_rep;
        n_rep_tot = r_rep_tot;
        n_rep_s   = r_rep_s;
        n_rep_l   = r_rep_l;
        n_out_valid = r_out_valid && !i_out_ready;
        div_req.start    = 1'b0;
        div_req.dividend = r_sum_s + r_sum_l;
        div_req.divisor  = r_cnt_tot;

        // monitor: take the pending press first, then step the blink
        goal_m = r_goal;
        step_m = r_step;
        if (r_pending) begin
            goal_m = r_long ? {r_lblk, 1'b0} : {r_sblk, 1'b0};
            step_m = '0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_rep   = 1'b0;
                    n_state = S_DONE;
                    case (i_op)
                        bpcs_pkg::OP_SAMPLE: begin
                            if (!r_pressed) begin
                                if (i_button_level) begin
                                    n_start   = i_now_ms;
                                    n_pressed = 1'b1;
                                    n_grn     = 1'b0;
                                    n_red     = 1'b0;
                                end
                            end else if (!i_button_level) begin
                                n_dur     = dur;
                                n_long    = (dur >= W'(r_thr));
                                n_pending = 1'b1;
                                if (dur >= W'(r_thr)) n_red = 1'b1;
                                else                  n_grn = 1'b1;
                                n_pressed = 1'b0;
                            end
                        end
                        bpcs_pkg::OP_MONITOR: begin
                            if (r_pending) begin
                                n_cnt_tot = r_cnt_tot + 1'b1;
                                if (r_long) begin
                                    n_cnt_l = r_cnt_l + 1'b1;
                                    n_sum_l = r_sum_l + r_dur;
                                end else begin
                                    n_cnt_s = r_cnt_s + 1'b1;
                                    n_sum_s = r_sum_s + r_dur;
                                end
                                n_pending = 1'b0;
                            end
                            n_goal = goal_m;
                            if (step_m < goal_m) begin
                                n_yel  = ~step_m[0];
                                n_step = step_m + 1'b1;
                            end else begin
                                n_yel  = 1'b0;
                                n_step = step_m;
                            end
                        end
                        bpcs_pkg::OP_REPORT: begin
                            n_rep     = 1'b1;
                            n_rep_tot = r_cnt_tot;
                            n_rep_s   = r_cnt_s;
                            n_rep_l   = r_cnt_l;
                            n_cnt_tot = '0;
                            n_cnt_s   = '0;
                            n_cnt_l   = '0;
                            n_sum_s   = '0;
                            n_sum_l   = '0;
                            if (r_cnt_tot != '0) begin
                                div_req.start = 1'b1;
                                n_state       = S_DIV;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                if (div_sts.done) n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register frees
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pressed   <= 1'b0;
            r_start     <= '0;
            r_pending   <= 1'b0;
            r_dur       <= '0;
            r_long      <= 1'b0;
            r_cnt_tot   <= '0;
            r_cnt_s     <= '0;
            r_cnt_l     <= '0;
            r_sum_s     <= '0;
            r_sum_l     <= '0;
            r_step      <= '0;
            r_goal      <= '0;
            r_grn       <= 1'b0;
            r_red       <= 1'b0;
            r_yel       <= 1'b0;
            r_rep       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pressed   <= n_pressed;
            r_start     <= n_start;
            r_pending   <= n_pending;
            r_dur       <= n_dur;
            r_long      <= n_long;
            r_cnt_tot   <= n_cnt_tot;
            r_cnt_s     <= n_cnt_s;
            r_cnt_l     <= n_cnt_l;
            r_sum_s     <= n_sum_s;
            r_sum_l     <= n_sum_l;
            r_step      <= n_step;
            r_goal      <= n_goal;
            r_grn       <= n_grn;
            r_red       <= n_red;
            r_yel       <= n_yel;
            r_rep       <= n_rep;
            r_out_valid <= n_out_valid;
        end
        r_rep_tot <= n_rep_tot;
        r_rep_s   <= n_rep_s;
        r_rep_l   <= n_rep_l;
    end

    // load the output beat when the sequencer finishes an item
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_o_grn   <= r_grn;
            r_o_red   <= r_red;
            r_o_yel   <= r_yel;
            r_o_rep   <= r_rep;
            r_o_tot   <= r_rep ? r_rep_tot : '0;
            r_o_s     <= r_rep ? r_rep_s : '0;
            r_o_l     <= r_rep ? r_rep_l : '0;
            r_o_avg_v <= r_rep && (r_rep_tot != '0);
            r_o_avg   <= (r_rep && (r_rep_tot != '0)) ? div_sts.quotient : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_green_led     = r_o_grn;
    assign o_red_led       = r_o_red;
    assign o_yellow_led    = r_o_yel;
    assign o_report_valid  = r_o_rep;
    assign o_total_count   = r_o_tot;
    assign o_short_count   = r_o_s;
    assign o_long_count    = r_o_l;
    assign o_average_ms    = r_o_avg;
    assign o_average_valid = r_o_avg_v;

    a_div_busy_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sts.busy |-> (r_state == S_DIV))
        else $error("divider busy outside the divide state");

    a_report_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_op == bpcs_pkg::OP_REPORT && r_cnt_tot != '0) |=> (r_state == S_DIV))
        else $error("report with presses did not start the divider");

    a_avg_needs_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_average_valid) |-> (o_report_valid && o_total_count != '0))
        else $error("average marked valid without a nonzero report");

    a_non_report_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_report_valid) |-> (o_total_count == '0 && o_average_ms == '0))
        else $error("non-report beat carries statistics");

endmodule

// File: tb/button_press_classifier_stats_checker.sv
module button_press_classifier_stats_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [bpcs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bpcs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic [1:0]                         i_op,
    input  logic                               i_button_level,
    input  logic [bpcs_pkg::DATA_W-1:0]        i_now_ms,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic                               i_green_led,
    input  logic                               i_red_led,
    input  logic                               i_yellow_led,
    input  logic                               i_report_valid,
    input  logic [bpcs_pkg::DATA_W-1:0]        i_total_count,
    input  logic [bpcs_pkg::DATA_W-1:0]        i_short_count,
    input  logic [bpcs_pkg::DATA_W-1:0]        i_long_count,
    input  logic [bpcs_pkg::DATA_W-1:0]        i_average_ms,
    input  logic                               i_average_valid,
    output int                                 o_fail_count,
    output int                                 o_pending
);

    typedef struct packed {
        logic                        green;
        logic                        red;
        logic                        yellow;
        logic                        rpt_valid;
        logic [bpcs_pkg::DATA_W-1:0] total_cnt;
        logic [bpcs_pkg::DATA_W-1:0] short_cnt;
        logic [bpcs_pkg::DATA_W-1:0] long_cnt;
        logic [bpcs_pkg::DATA_W-1:0] avg_ms;
        logic                        avg_valid;
    } t_led_report;

    t_led_report led_report_q[$];

    // configuration copy
    logic [bpcs_pkg::THR_W-1:0]  thr_ms;
    logic [bpcs_pkg::BLK_W-1:0]  short_blk;
    logic [bpcs_pkg::BLK_W-1:0]  long_blk;

    // classifier state
    logic                         btn_down;
    logic [bpcs_pkg::DATA_W-1:0]  start_ms;
    logic                         press_pending;
    logic [bpcs_pkg::DATA_W-1:0]  last_dur;
    logic                         last_long;
    logic [bpcs_pkg::DATA_W-1:0]  n_total;
    logic [bpcs_pkg::DATA_W-1:0]  n_short;
    logic [bpcs_pkg::DATA_W-1:0]  n_long;
    logic [bpcs_pkg::DATA_W-1:0]  sum_short;
    logic [bpcs_pkg::DATA_W-1:0]  sum_long;
    logic [bpcs_pkg::STEP_W-1:0]  blink_idx;
    logic [bpcs_pkg::STEP_W-1:0]  blink_end;
    logic                         led_g;
    logic                         led_r;
    logic                         led_y;

    int fail_cnt = 0;

    task automatic clear_classifier();
        thr_ms        = bpcs_pkg::THR_RESET;
        short_blk     = bpcs_pkg::SHORT_BLK_RESET;
        long_blk      = bpcs_pkg::LONG_BLK_RESET;
        btn_down      = 1'b0;
        start_ms      = '0;
        press_pending = 1'b0;
        last_dur      = '0;
        last_long     = 1'b0;
        n_total       = '0;
        n_short       = '0;
        n_long        = '0;
        sum_short     = '0;
        sum_long      = '0;
        blink_idx     = '0;
        blink_end     = '0;
        led_g         = 1'b0;
        led_r         = 1'b0;
        led_y         = 1'b0;
    endtask

    task automatic classify_beat(input logic [1:0] op, input logic lvl,
                                 input logic [bpcs_pkg::DATA_W-1:0] now_ms,
                                 output t_led_report res);
        logic [bpcs_pkg::DATA_W-1:0] dur;
        logic [bpcs_pkg::DATA_W-1:0] sum_all;
        res = '0;
        case (op)
            bpcs_pkg::OP_SAMPLE: begin
                if (!btn_down) begin
                    if (lvl) begin
                        start_ms = now_ms;
                        btn_down = 1'b1;
                        led_g    = 1'b0;
                        led_r    = 1'b0;
                    end
                end else if (!lvl) begin
                    dur           = now_ms - start_ms;
                    last_dur      = dur;
                    last_long     = (dur >= bpcs_pkg::DATA_W'(thr_ms));
                    press_pending = 1'b1;
                    if (last_long) begin
                        led_r = 1'b1;
                    end else begin
                        led_g = 1'b1;
                    end
                    btn_down = 1'b0;
                end
            end
            bpcs_pkg::OP_MONITOR: begin
                // count the finished press first, then step the blink
                if (press_pending) begin
                    n_total = n_total + 1'b1;
                    if (last_long) begin
                        n_long    = n_long + 1'b1;
                        sum_long  = sum_long + last_dur;
                        blink_end = {long_blk, 1'b0};
                    end else begin
                        n_short   = n_short + 1'b1;
                        sum_short = sum_short + last_dur;
                        blink_end = {short_blk, 1'b0};
                    end
                    blink_idx     = '0;
                    press_pending = 1'b0;
                end
                if (blink_idx < blink_end) begin
                    led_y     = ~blink_idx[0];
                    blink_idx = blink_idx + 1'b1;
                end else begin
                    led_y = 1'b0;
                end
            end
            bpcs_pkg::OP_REPORT: begin
                sum_all       = sum_short + sum_long;
                res.rpt_valid = 1'b1;
                res.total_cnt = n_total;
                res.short_cnt = n_short;
                res.long_cnt  = n_long;
                if (n_total != '0) begin
                    res.avg_ms    = sum_all / n_total;
                    res.avg_valid = 1'b1;
                end
                // pending press and blink survive the report
                n_total   = '0;
                n_short   = '0;
                n_long    = '0;
                sum_short = '0;
                sum_long  = '0;
            end
            default: begin
            end
        endcase
        res.green  = led_g;
        res.red    = led_r;
        res.yellow = led_y;
    endtask

    task automatic check_field(input string name, input logic [bpcs_pkg::DATA_W-1:0] exp_v,
                               input logic [bpcs_pkg::DATA_W-1:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_led_report exp_r;
        t_led_report new_r;
        if (!i_rst_n) begin
            clear_classifier();
            led_report_q.delete();
        end else begin
            // retire the oldest expectation before adding a new one
            if (i_out_valid && i_out_ready) begin
                if (led_report_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $time);
                    fail_cnt++;
                end else begin
                    exp_r = led_report_q.pop_front();
                    check_field("green_led", bpcs_pkg::DATA_W'(exp_r.green),
                                bpcs_pkg::DATA_W'(i_green_led));
                    check_field("red_led", bpcs_pkg::DATA_W'(exp_r.red),
                                bpcs_pkg::DATA_W'(i_red_led));
                    check_field("yellow_led", bpcs_pkg::DATA_W'(exp_r.yellow),
                                bpcs_pkg::DATA_W'(i_yellow_led));
                    check_field("report_valid", bpcs_pkg::DATA_W'(exp_r.rpt_valid),
                                bpcs_pkg::DATA_W'(i_report_valid));
                    check_field("total_count", exp_r.total_cnt, i_total_count);
                    check_field("short_count", exp_r.short_cnt, i_short_count);
                    check_field("long_count", exp_r.long_cnt, i_long_count);
                    check_field("average_ms", exp_r.avg_ms, i_average_ms);
                    check_field("average_valid", bpcs_pkg::DATA_W'(exp_r.avg_valid),
                                bpcs_pkg::DATA_W'(i_average_valid));
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    bpcs_pkg::CFG_THRESHOLD:   thr_ms    = i_cfg_data[bpcs_pkg::THR_W-1:0];
                    bpcs_pkg::CFG_SHORT_BLINK: short_blk = i_cfg_data[bpcs_pkg::BLK_W-1:0];
                    bpcs_pkg::CFG_LONG_BLINK:  long_blk  = i_cfg_data[bpcs_pkg::BLK_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                classify_beat(i_op, i_button_level, i_now_ms, new_r);
                led_report_q.push_back(new_r);
            end
        end
        o_pending = led_report_q.size();
    end

    assign o_fail_count = fail_cnt;

endmodule

// File: tb/tb_button_press_classifier_stats_top.sv
module tb_button_press_classifier_stats_top;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         PHASE_BEATS = 140;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [bpcs_pkg::CFG_IDX_W-1:0]  cfg_idx = bpcs_pkg::CFG_THRESHOLD;
    logic [bpcs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [1:0]                      op = bpcs_pkg::OP_SAMPLE;
    logic                            button_level = 1'b0;
    logic [bpcs_pkg::DATA_W-1:0]     now_ms = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic                            green_led;
    logic                            red_led;
    logic                            yellow_led;
    logic                            report_valid;
    logic [bpcs_pkg::DATA_W-1:0]     total_count;
    logic [bpcs_pkg::DATA_W-1:0]     short_count;
    logic [bpcs_pkg::DATA_W-1:0]     long_count;
    logic [bpcs_pkg::DATA_W-1:0]     average_ms;
    logic                            average_valid;

    int fail_cnt;
    int pending_cnt;
    int cycle_cnt = 0;
    int tx_idle_pct = 12;
    int rx_idle_pct = 49;
    int beats_sent = 0;
    logic [bpcs_pkg::THR_W-1:0]  thr_now = bpcs_pkg::THR_RESET;
    logic [bpcs_pkg::DATA_W-1:0] clock_ms;

    button_press_classifier_stats_top u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_op           (op),
        .i_button_level (button_level),
        .i_now_ms       (now_ms),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_green_led    (green_led),
        .o_red_led      (red_led),
        .o_yellow_led   (yellow_led),
        .o_report_valid (report_valid),
        .o_total_count  (total_count),
        .o_short_count  (short_count),
        .o_long_count   (long_count),
        .o_average_ms   (average_ms),
        .o_average_valid(average_valid)
    );

    button_press_classifier_stats_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_op           (op),
        .i_button_level (button_level),
        .i_now_ms       (now_ms),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_green_led    (green_led),
        .i_red_led      (red_led),
        .i_yellow_led   (yellow_led),
        .i_report_valid (report_valid),
        .i_total_count  (total_count),
        .i_short_count  (short_count),
        .i_long_count   (long_count),
        .i_average_ms   (average_ms),
        .i_average_valid(average_valid),
        .o_fail_count   (fail_cnt),
        .o_pending      (pending_cnt)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("button_press_classifier_stats_top: mismatch");
            $finish;
        end
    end

    // Call at a rising edge; returns at the edge where the beat is taken.
    task automatic drive_beat(input logic [1:0] b_op, input logic lvl,
                              input logic [bpcs_pkg::DATA_W-1:0] t_ms);
        if ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(8, 40)) @(posedge clk);
            end else begin
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
        end
        in_valid     <= 1'b1;
        op           <= b_op;
        button_level <= lvl;
        now_ms       <= t_ms;
        // ready only moves at rising edges, so a high level here means taken next edge
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        beats_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_cnt != 0);
        @(posedge clk);
    endtask

    task automatic write_config(input logic [bpcs_pkg::THR_W-1:0] thr,
                                input logic [bpcs_pkg::BLK_W-1:0] s_blk,
                                input logic [bpcs_pkg::BLK_W-1:0] l_blk);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= bpcs_pkg::CFG_THRESHOLD;
        cfg_data  <= bpcs_pkg::CFG_DATA_W'(thr);
        @(posedge clk);
        cfg_idx   <= bpcs_pkg::CFG_SHORT_BLINK;
        cfg_data  <= bpcs_pkg::CFG_DATA_W'(s_blk);
        @(posedge clk);
        cfg_idx   <= bpcs_pkg::CFG_LONG_BLINK;
        cfg_data  <= bpcs_pkg::CFG_DATA_W'(l_blk);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        thr_now = thr;
    endtask

    task automatic run_presses(input int n_beats);
        int stop_at;
        int hold_at;
        int ticks;
        int thr_i;
        logic [bpcs_pkg::DATA_W-1:0] dur;
        logic [bpcs_pkg::DATA_W-1:0] t0;
        stop_at = beats_sent + n_beats;
        hold_at = beats_sent + 60;
        while (beats_sent < stop_at) begin
            thr_i = int'(thr_now);
            if ($urandom_range(99) < 78) begin
                case ($urandom_range(3))
                    0:       dur = bpcs_pkg::DATA_W'(thr_i)
                                   + bpcs_pkg::DATA_W'($urandom_range(4)) - 32'd2;
                    1:       dur = $urandom_range(0, 2 * thr_i + 10);
                    2:       dur = $urandom();
                    default: dur = $urandom_range(0, 50);
                endcase
                t0 = clock_ms;
                drive_beat(bpcs_pkg::OP_SAMPLE, 1'b1, t0);
                if ($urandom_range(99) < 20) begin
                    drive_beat(bpcs_pkg::OP_SAMPLE, 1'b1, $urandom());
                end
                drive_beat(bpcs_pkg::OP_SAMPLE, 1'b0, t0 + dur);
                if ($urandom_range(99) < 15) begin
                    drive_beat(bpcs_pkg::OP_SAMPLE, 1'b0, $urandom());
                end
                clock_ms = t0 + dur + bpcs_pkg::DATA_W'($urandom_range(1, 1000));
                if ($urandom_range(9) == 0) begin
                    ticks = $urandom_range(20, 34);
                end else begin
                    ticks = $urandom_range(0, 6);
                end
                repeat (ticks) drive_beat(bpcs_pkg::OP_MONITOR, 1'($urandom_range(1)),
                                          $urandom());
                if ($urandom_range(99) < 15) begin
                    drive_beat(bpcs_pkg::OP_REPORT, 1'($urandom_range(1)), $urandom());
                end
            end else begin
                drive_beat(2'($urandom_range(3)), 1'($urandom_range(1)), $urandom());
            end
            // hold off until every result is back
            if (beats_sent >= hold_at) begin
                wait_drained();
                hold_at = beats_sent + 60;
            end
        end
    endtask

    initial begin
        clock_ms = $urandom();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, 500 ms threshold
        drive_beat(bpcs_pkg::OP_REPORT, 1'b0, 32'd0);
        drive_beat(OP_UNUSED, 1'b1, 32'hFFFF_FFFF);
        drive_beat(bpcs_pkg::OP_SAMPLE, 1'b0, 32'd5);
        drive_beat(bpcs_pkg::OP_SAMPLE, 1'b1, 32'hFFFF_FFF0);
        drive_beat(bpcs_pkg::OP_SAMPLE, 1'b1, 32'h1234_5678);
        drive_beat(bpcs_pkg::OP_SAMPLE, 1'b0, 32'h0000_0010);
        drive_beat(bpcs_pkg::OP_MONITOR, 1'b0, 32'd0);
        drive_beat(bpcs_pkg::OP_MONITOR, 1'b1, 32'd0);
        drive_beat(bpcs_pkg::OP_SAMPLE, 1'b1, 32'd0);
        drive_beat(bpcs_pkg::OP_SAMPLE, 1'b0, 32'hFFFF_FFFF);
        drive_beat(bpcs_pkg::OP_SAMPLE, 1'b1, 32'd100);
        drive_beat(bpcs_pkg::OP_SAMPLE, 1'b0, 32'd599);
        drive_beat(bpcs_pkg::OP_SAMPLE, 1'b1, 32'd1000);
        drive_beat(bpcs_pkg::OP_SAMPLE, 1'b0, 32'd1500);
        drive_beat(bpcs_pkg::OP_MONITOR, 1'b0, 32'd0);
        drive_beat(bpcs_pkg::OP_REPORT, 1'b0, 32'd0);
        drive_beat(bpcs_pkg::OP_REPORT, 1'b1, 32'hFFFF_FFFF);
        repeat (8) drive_beat(bpcs_pkg::OP_MONITOR, 1'b0, 32'd0);
        wait_drained();

        // every press long, short blink off, longest long blink
        write_config(16'd0, 4'd0, 4'd15);
        drive_beat(bpcs_pkg::OP_SAMPLE, 1'b1, 32'd7);
        drive_beat(bpcs_pkg::OP_SAMPLE, 1'b0, 32'd7);
        drive_beat(bpcs_pkg::OP_MONITOR, 1'b0, 32'd0);
        drive_beat(bpcs_pkg::OP_REPORT, 1'b0, 32'd0);
        run_presses(PHASE_BEATS);
        wait_drained();

        tx_idle_pct = 49;
        rx_idle_pct = 12;
        write_config(16'hFFFF, 4'd15, 4'd0);
        run_presses(PHASE_BEATS);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_config(bpcs_pkg::THR_W'($urandom_range(1, 1500)),
                     bpcs_pkg::BLK_W'($urandom_range(15)),
                     bpcs_pkg::BLK_W'($urandom_range(15)));
        run_presses(PHASE_BEATS);
        wait_drained();

        // let any stray result show up
        repeat (60) @(posedge clk);
        if (fail_cnt == 0) begin
            $display("button_press_classifier_stats_top: match");
        end else begin
            $display("button_press_classifier_stats_top: mismatch");
        end
        $finish;
    end

endmodule

// File: button_press_classifier_stats_top.f
sv/bpcs_pkg.sv
sv/bpcs_div.sv
sv/button_press_classifier_stats_top.sv
tb/button_press_classifier_stats_checker.sv
tb/tb_button_press_classifier_stats_top.sv
